>>> hw/rtl/ttf_pkg.sv
// package for the triangle tangent frame block: defaults, state and return codes
`timescale 1ns / 1ps
`default_nettype none
package ttf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REDUCE,
        S_TR,
        S_BR,
        S_CRS,
        S_DOTC,
        S_DTN,
        S_U,
        S_BN,
        S_NMAG,
        S_NSCALE,
        S_NSQ,
        S_NSQRT,
        S_NDINIT,
        S_NDIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RET_T,
        RET_B,
        RET_TN
    } t_ret;

endpackage
`default_nettype wire

>>> hw/rtl/triangle_tangent_frame.sv
// triangle tangent frame: top level with shared multiplier, root and divider sequencer
//
//  channel  | handshake          | payload
//  vertex   | i_valid / o_ready  | i_pos_x/y/z, i_tex_u/v, i_norm_x/y/z
//  frame    | o_valid / i_ready  | o_tan_x/y/z, o_bitan_x/y/z, o_degenerate
//
// the first two corners of a triangle are stored in idle, with o_ready held high
// the third corner starts the sequencer; each normalisation takes shift steps to scale the
// vector, 32 root steps and FRAC_BITS + 2 divide steps for each of the three components
// all of these share the single 33 x 33 multiplier and the bit-serial root and divider
// reset clears the sequencer, the corner count and the frame valid
// a frame still waiting on i_ready holds the next frame in its last step, with o_ready low
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_frame
    import ttf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_tex_u,
    input  logic signed [31:0] i_tex_v,
    input  logic signed [17:0] i_norm_x,
    input  logic signed [17:0] i_norm_y,
    input  logic signed [17:0] i_norm_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [17:0] o_tan_x,
    output logic signed [17:0] o_tan_y,
    output logic signed [17:0] o_tan_z,
    output logic signed [17:0] o_bitan_x,
    output logic signed [17:0] o_bitan_y,
    output logic signed [17:0] o_bitan_z,
    output logic               o_degenerate
);

    localparam int TW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 2;
    localparam int KW = $clog2(QW + 1);

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    logic [1:0] r_cnt, n_cnt;
    logic r_ovalid, n_ovalid;

    logic signed [31:0] r_pos [6], n_pos [6];
    logic signed [31:0] r_tex [4], n_tex [4];
    logic signed [17:0] r_nrm [3], n_nrm [3];
    logic signed [32:0] r_e [6], n_e [6];
    logic signed [32:0] r_w [4], n_w [4];
    logic signed [63:0] r_vec [3], n_vec [3];
    logic [63:0] r_a [3], n_a [3];
    logic [2:0] r_sgn, n_sgn;
    logic signed [TW-1:0] r_t [3], n_t [3];
    logic signed [TW-1:0] r_b [3], n_b [3];
    logic signed [32:0] r_dtn, n_dtn;
    logic [1:0] r_i, n_i, r_j, n_j;
    logic r_ph, n_ph;
    logic signed [63:0] r_acc, n_acc, r_prod, n_prod;
    logic r_deg, n_deg;
    logic [63:0] r_x, n_x, r_res, n_res, r_bit, n_bit;
    logic [31:0] r_len, n_len;
    logic [63:0] r_rem, n_rem, r_dsh, n_dsh;
    logic [QW-1:0] r_q, n_q;
    logic [KW-1:0] r_k, n_k;
    logic signed [17:0] r_otan [3], n_otan [3];
    logic signed [17:0] r_obtn [3], n_obtn [3];
    logic r_odeg, n_odeg;

    logic signed [32:0] op_a, op_b;
    logic op_neg;
    logic [1:0] last_i, last_j;
    logic signed [65:0] w_prod;
    logic signed [63:0] w_term, w_acc, w_rnd;
    logic [63:0] w_sq;
    logic w_ge;
    logic [QW-1:0] w_q;
    logic signed [TW-1:0] w_qs;
    logic se, sw, big, tiny;

    function automatic logic [1:0] nx1(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic logic [1:0] nx2(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : i - 2'd1;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        logic [63:0] m, r;
        m = v[63] ? (~v + 64'd1) : v;
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? (~r + 64'd1) : r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        return d[32] ? (~d + 33'd1) : d;
    endfunction

    function automatic logic big33(input logic signed [32:0] d);
        logic [32:0] m;
        m = mag33(d);
        return m[32] | m[31];
    endfunction

    function automatic logic signed [32:0] red33(input logic signed [32:0] d, input logic s);
        logic [32:0] m;
        m = mag33(d);
        if (s) begin
            m = m >> 1;
        end
        return d[32] ? (~m + 33'd1) : m;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
        if (v > 64'sd131071) begin
            return 18'sd131071;
        end
        if (v < -64'sd131072) begin
            return -18'sd131072;
        end
        return v[17:0];
    endfunction

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_tan_x      = r_otan[0];
    assign o_tan_y      = r_otan[1];
    assign o_tan_z      = r_otan[2];
    assign o_bitan_x    = r_obtn[0];
    assign o_bitan_y    = r_obtn[1];
    assign o_bitan_z    = r_obtn[2];
    assign o_degenerate = r_odeg;

    // shared multiplier operands
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        last_i = 2'd2;
        last_j = 2'd1;
        case (r_state)
            S_TR: begin
                op_neg = r_j[0];
                op_a   = r_j[0] ? r_e[3'd3 + {1'b0, r_i}] : r_e[{1'b0, r_i}];
                op_b   = r_j[0] ? r_w[1] : r_w[3];
            end
            S_BR: begin
                op_neg = r_j[0];
                op_a   = r_j[0] ? r_e[{1'b0, r_i}] : r_e[3'd3 + {1'b0, r_i}];
                op_b   = r_j[0] ? r_w[2] : r_w[0];
            end
            S_CRS: begin
                op_neg = r_j[0];
                op_a   = 33'(r_t[r_j[0] ? nx2(r_i) : nx1(r_i)]);
                op_b   = 33'(r_b[r_j[0] ? nx1(r_i) : nx2(r_i)]);
            end
            S_BN: begin
                op_neg = r_j[0];
                op_a   = 33'(r_nrm[r_j[0] ? nx2(r_i) : nx1(r_i)]);
                op_b   = 33'(r_t[r_j[0] ? nx1(r_i) : nx2(r_i)]);
            end
            S_DOTC: begin
                last_i = 2'd0;
                last_j = 2'd2;
                op_a   = signed'(r_vec[r_j][32:0]);
                op_b   = 33'(r_nrm[r_j]);
            end
            S_DTN: begin
                last_i = 2'd0;
                last_j = 2'd2;
                op_a   = 33'(r_t[r_j]);
                op_b   = 33'(r_nrm[r_j]);
            end
            S_U: begin
                last_j = 2'd0;
                op_a   = 33'(r_nrm[r_i]);
                op_b   = r_dtn;
            end
            S_NSQ: begin
                last_i = 2'd0;
                last_j = 2'd2;
                op_a   = signed'({1'b0, r_a[r_j][31:0]});
                op_b   = signed'({1'b0, r_a[r_j][31:0]});
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign w_prod = op_a * op_b;
    assign w_term = op_neg ? -r_prod : r_prod;
    assign w_acc  = ((r_j == 2'd0) ? 64'sd0 : r_acc) + w_term;
    assign w_rnd  = rnd(w_acc);
    assign w_sq   = r_res + r_bit;
    assign w_ge   = (r_rem >= r_dsh);
    assign w_q    = {r_q[QW-2:0], w_ge};
    assign w_qs   = signed'(w_q);

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_pos    = r_pos;
        n_tex    = r_tex;
        n_nrm    = r_nrm;
        n_e      = r_e;
        n_w      = r_w;
        n_vec    = r_vec;
        n_a      = r_a;
        n_sgn    = r_sgn;
        n_t      = r_t;
        n_b      = r_b;
        n_dtn    = r_dtn;
        n_i      = r_i;
        n_j      = r_j;
        n_ph     = r_ph;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_deg    = r_deg;
        n_x      = r_x;
        n_res    = r_res;
        n_bit    = r_bit;
        n_len    = r_len;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_q      = r_q;
        n_k      = r_k;
        n_otan   = r_otan;
        n_obtn   = r_obtn;
        n_odeg   = r_odeg;
        se       = 1'b0;
        sw       = 1'b0;
        big      = 1'b0;
        tiny     = 1'b1;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_cnt == 2'd0) begin
                        n_pos[0] = i_pos_x;
                        n_pos[1] = i_pos_y;
                        n_pos[2] = i_pos_z;
                        n_tex[0] = i_tex_u;
                        n_tex[1] = i_tex_v;
                        n_nrm[0] = i_norm_x;
                        n_nrm[1] = i_norm_y;
                        n_nrm[2] = i_norm_z;
                        n_cnt    = 2'd1;
                    end else if (r_cnt == 2'd1) begin
                        n_pos[3] = i_pos_x;
                        n_pos[4] = i_pos_y;
                        n_pos[5] = i_pos_z;
                        n_tex[2] = i_tex_u;
                        n_tex[3] = i_tex_v;
                        n_cnt    = 2'd2;
                    end else begin
                        n_e[0]  = 33'(r_pos[3]) - 33'(r_pos[0]);
                        n_e[1]  = 33'(r_pos[4]) - 33'(r_pos[1]);
                        n_e[2]  = 33'(r_pos[5]) - 33'(r_pos[2]);
                        n_e[3]  = 33'(i_pos_x) - 33'(r_pos[0]);
                        n_e[4]  = 33'(i_pos_y) - 33'(r_pos[1]);
                        n_e[5]  = 33'(i_pos_z) - 33'(r_pos[2]);
                        n_w[0]  = 33'(r_tex[2]) - 33'(r_tex[0]);
                        n_w[1]  = 33'(r_tex[3]) - 33'(r_tex[1]);
                        n_w[2]  = 33'(i_tex_u) - 33'(r_tex[0]);
                        n_w[3]  = 33'(i_tex_v) - 33'(r_tex[1]);
                        n_cnt   = 2'd0;
                        n_deg   = 1'b0;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                for (int k = 0; k < 6; k++) begin
                    se = se | big33(r_e[k]);
                end
                for (int k = 0; k < 4; k++) begin
                    sw = sw | big33(r_w[k]);
                end
                for (int k = 0; k < 6; k++) begin
                    n_e[k] = red33(r_e[k], se);
                end
                for (int k = 0; k < 4; k++) begin
                    n_w[k] = red33(r_w[k], sw);
                end
                n_i     = 2'd0;
                n_j     = 2'd0;
                n_ph    = 1'b0;
                n_state = S_TR;
            end
            S_TR, S_BR, S_CRS, S_DOTC, S_DTN, S_U, S_BN, S_NSQ: begin
                if (!r_ph) begin
                    n_prod = w_prod[63:0];
                    n_ph   = 1'b1;
                end else begin
                    n_ph  = 1'b0;
                    n_acc = w_acc;
                    if (r_j != last_j) begin
                        n_j = r_j + 2'd1;
                    end else begin
                        n_j = 2'd0;
                        case (r_state)
                            S_TR, S_BR: n_vec[r_i] = w_acc;
                            S_CRS, S_BN: n_vec[r_i] = w_rnd;
                            S_DOTC: begin
                                if (w_acc[63]) begin
                                    for (int k = 0; k < 3; k++) begin
                                        n_t[k] = -r_t[k];
                                    end
                                end
                            end
                            S_DTN: n_dtn = w_rnd[32:0];
                            S_U: n_vec[r_i] = 64'(r_t[r_i]) - w_rnd;
                            default: begin
                                n_x   = w_acc;
                                n_res = '0;
                                n_bit = 64'd1 << 62;
                            end
                        endcase
                        if (r_i != last_i) begin
                            n_i = r_i + 2'd1;
                        end else begin
                            n_i = 2'd0;
                            case (r_state)
                                S_TR: begin
                                    n_ret   = RET_T;
                                    n_state = S_NMAG;
                                end
                                S_BR: begin
                                    n_ret   = RET_B;
                                    n_state = S_NMAG;
                                end
                                S_CRS:  n_state = S_DOTC;
                                S_DOTC: n_state = S_DTN;
                                S_DTN:  n_state = S_U;
                                S_U: begin
                                    n_ret   = RET_TN;
                                    n_state = S_NMAG;
                                end
                                S_BN:   n_state = S_OUT;
                                default: n_state = S_NSQRT;
                            endcase
                        end
                    end
                end
            end
            S_NMAG: begin
                for (int k = 0; k < 3; k++) begin
                    n_a[k]   = mag64(r_vec[k]);
                    n_sgn[k] = r_vec[k][63];
                end
                n_i = 2'd0;
                n_j = 2'd0;
                if (r_vec[0] == 64'sd0 && r_vec[1] == 64'sd0 && r_vec[2] == 64'sd0) begin
                    n_deg = 1'b1;
                    case (r_ret)
                        RET_T:   n_state = S_BR;
                        RET_B:   n_state = S_CRS;
                        default: n_state = S_BN;
                    endcase
                end else begin
                    n_state = S_NSCALE;
                end
            end
            S_NSCALE: begin
                for (int k = 0; k < 3; k++) begin
                    big  = big | (r_a[k][63:30] != '0);
                    tiny = tiny & (r_a[k][63:29] == '0);
                end
                if (big) begin
                    for (int k = 0; k < 3; k++) begin
                        n_a[k] = r_a[k] >> 1;
                    end
                end else if (tiny) begin
                    for (int k = 0; k < 3; k++) begin
                        n_a[k] = r_a[k] << 1;
                    end
                end else begin
                    n_ph    = 1'b0;
                    n_state = S_NSQ;
                end
            end
            S_NSQRT: begin
                if (r_bit == '0) begin
                    n_len   = r_res[31:0];
                    n_i     = 2'd0;
                    n_state = S_NDINIT;
                end else begin
                    if (r_x >= w_sq) begin
                        n_x   = r_x - w_sq;
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            S_NDINIT: begin
                n_rem   = (r_a[r_i] << FRAC_BITS) + 64'(r_len >> 1);
                n_dsh   = 64'(r_len) << (FRAC_BITS + 1);
                n_q     = '0;
                n_k     = '0;
                n_state = S_NDIV;
            end
            S_NDIV: begin
                if (w_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = w_q;
                n_dsh = r_dsh >> 1;
                n_k   = r_k + KW'(1);
                if (r_k == KW'(QW - 1)) begin
                    if (r_ret == RET_B) begin
                        n_b[r_i] = r_sgn[r_i] ? -w_qs : w_qs;
                    end else begin
                        n_t[r_i] = r_sgn[r_i] ? -w_qs : w_qs;
                    end
                    if (r_i == 2'd2) begin
                        n_i = 2'd0;
                        n_j = 2'd0;
                        case (r_ret)
                            RET_T:   n_state = S_BR;
                            RET_B:   n_state = S_CRS;
                            default: n_state = S_BN;
                        endcase
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_state = S_NDINIT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odeg   = r_deg;
                    for (int k = 0; k < 3; k++) begin
                        n_otan[k] = r_deg ? 18'sd0 : sat18(64'(r_t[k]));
                        n_obtn[k] = r_deg ? 18'sd0 : sat18(r_vec[k]);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_pos  <= n_pos;
        r_tex  <= n_tex;
        r_nrm  <= n_nrm;
        r_e    <= n_e;
        r_w    <= n_w;
        r_vec  <= n_vec;
        r_a    <= n_a;
        r_sgn  <= n_sgn;
        r_t    <= n_t;
        r_b    <= n_b;
        r_dtn  <= n_dtn;
        r_i    <= n_i;
        r_j    <= n_j;
        r_ph   <= n_ph;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_deg  <= n_deg;
        r_x    <= n_x;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_len  <= n_len;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_k    <= n_k;
        r_otan <= n_otan;
        r_obtn <= n_obtn;
        r_odeg <= n_odeg;
    end

endmodule
`default_nettype wire
